// ===== rtl/ssh_pkg.sv =====
// ----------------------------------------------------------------------------
// ssh_pkg
// Shared types, constants and mixing functions for the stream hash block.
// ----------------------------------------------------------------------------
package ssh_pkg;

  localparam int unsigned HashW  = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned HalfW  = 16;
  localparam int unsigned HeldW  = 24;
  localparam int unsigned PhaseW = 2;

  localparam logic [PhaseW-1:0] PhaseFull = 2'd3;

  // Shift amounts of the main round, tail rule and avalanche
  localparam int unsigned Sh1  = 1;
  localparam int unsigned Sh3  = 3;
  localparam int unsigned Sh4  = 4;
  localparam int unsigned Sh5  = 5;
  localparam int unsigned Sh6  = 6;
  localparam int unsigned Sh10 = 10;
  localparam int unsigned Sh11 = 11;
  localparam int unsigned Sh16 = 16;
  localparam int unsigned Sh17 = 17;
  localparam int unsigned Sh18 = 18;
  localparam int unsigned Sh25 = 25;

  // One command from the front to the back
  typedef struct packed {
    logic               seed_vld;
    logic [HashW-1:0]   seed;
    logic               round_vld;
    logic [HalfW-1:0]   lo;
    logic [HalfW-1:0]   hi;
    logic               fin_vld;
    logic [HeldW-1:0]   held;
    logic [PhaseW-1:0]  count;
    logic               empty;
  } cmd_t;

  localparam int unsigned PipeStages = 4;

  typedef struct packed {
    logic [PipeStages-1:0] pipe_vld;
  } bk_status_t;

  function automatic logic [HashW-1:0] main_round(logic [HashW-1:0] h_in,
                                                  logic [HalfW-1:0] lo,
                                                  logic [HalfW-1:0] hi);
    logic [HashW-1:0] h;
    logic [HashW-1:0] t;
    h = h_in + {{(HashW-HalfW){1'b0}}, lo};
    t = ({{(HashW-HalfW){1'b0}}, hi} << Sh11) ^ h;
    h = (h << Sh16) ^ t;
    h = h + (h >> Sh11);
    return h;
  endfunction

  function automatic logic [HashW-1:0] tail_mix(logic [HashW-1:0] h_in,
                                                logic [HeldW-1:0] held,
                                                logic [PhaseW-1:0] count);
    logic [HashW-1:0] h;
    h = h_in;
    unique case (count)
      2'd3: begin
        h = h + {{(HashW-HalfW){1'b0}}, held[HalfW-1:0]};
        h = h ^ (h << Sh16);
        h = h ^ ({{(HashW-ByteW){1'b0}}, held[HeldW-1:HalfW]} << Sh18);
        h = h + (h >> Sh11);
      end
      2'd2: begin
        h = h + {{(HashW-HalfW){1'b0}}, held[HalfW-1:0]};
        h = h ^ (h << Sh11);
        h = h + (h >> Sh17);
      end
      2'd1: begin
        h = h + {{(HashW-ByteW){1'b0}}, held[ByteW-1:0]};
        h = h ^ (h << Sh10);
        h = h + (h >> Sh1);
      end
      default: h = h_in;
    endcase
    return h;
  endfunction

  // Avalanche, split in three parts of one xor-shift and one add each
  function automatic logic [HashW-1:0] aval_a(logic [HashW-1:0] h_in);
    logic [HashW-1:0] h;
    h = h_in ^ (h_in << Sh3);
    h = h + (h >> Sh5);
    return h;
  endfunction

  function automatic logic [HashW-1:0] aval_b(logic [HashW-1:0] h_in);
    logic [HashW-1:0] h;
    h = h_in ^ (h_in << Sh4);
    h = h + (h >> Sh17);
    return h;
  endfunction

  function automatic logic [HashW-1:0] aval_c(logic [HashW-1:0] h_in);
    logic [HashW-1:0] h;
    h = h_in ^ (h_in << Sh25);
    h = h + (h >> Sh6);
    return h;
  endfunction

endpackage

// ===== rtl/ssh_front.sv =====
// ----------------------------------------------------------------------------
// ssh_front
// Accepts bytes, tracks message framing and byte grouping, and issues seed,
// round and finish commands to the back end.
// ----------------------------------------------------------------------------
module ssh_front import ssh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ByteW-1:0]  data_byte_i,
  input  logic              byte_present_i,
  input  logic              message_start_i,
  input  logic              message_end_i,
  input  logic [HashW-1:0]  message_length_i,
  output logic              cmd_push_o,
  output cmd_t              cmd_o,
  input  logic              cmd_full_i
);

  logic              in_msg_q, in_msg_d;
  logic              any_q, any_d;
  logic [HeldW-1:0]  held_q, held_d;
  logic [PhaseW-1:0] phase_q, phase_d;

  logic              accept;
  logic              msg_eff;
  logic              any_eff;
  logic [HeldW-1:0]  held_eff;
  logic [PhaseW-1:0] phase_eff;
  logic              round;

  assign in_ready_o = !cmd_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    // A start drops any open message and reopens with a clean group
    msg_eff   = message_start_i || in_msg_q;
    any_eff   = message_start_i ? 1'b0 : any_q;
    held_eff  = message_start_i ? '0 : held_q;
    phase_eff = message_start_i ? '0 : phase_q;

    round   = 1'b0;
    held_d  = held_eff;
    phase_d = phase_eff;
    any_d   = any_eff;
    in_msg_d = msg_eff;

    if (msg_eff && byte_present_i) begin
      any_d = 1'b1;
      if (phase_eff == PhaseFull) begin
        round   = 1'b1;
        held_d  = '0;
        phase_d = '0;
      end else begin
        unique case (phase_eff)
          2'd0:    held_d[ByteW-1:0]       = data_byte_i;
          2'd1:    held_d[2*ByteW-1:ByteW] = data_byte_i;
          default: held_d[HeldW-1:2*ByteW] = data_byte_i;
        endcase
        phase_d = phase_eff + 2'd1;
      end
    end

    cmd_o.seed_vld  = message_start_i;
    cmd_o.seed      = message_length_i;
    cmd_o.round_vld = round;
    cmd_o.lo        = held_eff[HalfW-1:0];
    cmd_o.hi        = {data_byte_i, held_eff[HeldW-1:HalfW]};
    cmd_o.fin_vld   = message_end_i;
    cmd_o.held      = held_d;
    cmd_o.count     = phase_d;
    cmd_o.empty     = !any_d;

    cmd_push_o = accept && msg_eff && (message_start_i || round || message_end_i);

    if (msg_eff && message_end_i) begin
      in_msg_d = 1'b0;
      any_d    = 1'b0;
      held_d   = '0;
      phase_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q <= 1'b0;
      any_q    <= 1'b0;
      held_q   <= '0;
      phase_q  <= '0;
    end else if (accept) begin
      in_msg_q <= in_msg_d;
      any_q    <= any_d;
      held_q   <= held_d;
      phase_q  <= phase_d;
    end
  end

endmodule

// ===== rtl/ssh_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// ssh_cmd_fifo
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module ssh_cmd_fifo import ssh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cmd_t       cmd_i,
  output logic       full_o,
  output logic       valid_o,
  output cmd_t       cmd_o,
  input  logic       pop_i,
  output logic [1:0] cnt_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign cnt_o   = cnt_q;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

endmodule

// ===== rtl/ssh_back.sv =====
// ----------------------------------------------------------------------------
// ssh_back
// Runs seed and main-round commands on the running hash and passes finished
// messages through the tail and avalanche pipeline to the output register.
// ----------------------------------------------------------------------------
module ssh_back import ssh_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  output logic             hash_valid_o,
  input  logic             hash_ready_i,
  output logic [HashW-1:0] hash_value_o,
  output bk_status_t       status_o
);

  logic [HashW-1:0]  run_q, run_d;

  // Stage 1: hash before tail, stage 2: after tail, stages 3-4: avalanche
  logic [PipeStages-1:0] vld_q;
  logic [HashW-1:0]      h1_q, h2_q, h3_q, h4_q;
  logic [HeldW-1:0]      held1_q;
  logic [PhaseW-1:0]     cnt1_q;
  logic                  empty1_q;
  logic                  out_vld_q;
  logic [HashW-1:0]      out_q;

  logic [PipeStages-1:0] adv;
  logic                  out_rdy;
  logic [HashW-1:0]      h_cmd;

  assign out_rdy = !out_vld_q || hash_ready_i;

  always_comb begin
    adv[3] = !vld_q[3] || out_rdy;
    adv[2] = !vld_q[2] || adv[3];
    adv[1] = !vld_q[1] || adv[2];
    adv[0] = !vld_q[0] || adv[1];
  end

  assign cmd_pop_o = cmd_valid_i && adv[0];

  always_comb begin
    h_cmd = cmd_i.seed_vld ? cmd_i.seed : run_q;
    if (cmd_i.round_vld) begin
      h_cmd = main_round(run_q, cmd_i.lo, cmd_i.hi);
    end
    run_d = h_cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= '0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_pop_o) begin
        run_q <= run_d;
      end
      if (adv[0]) vld_q[0] <= cmd_pop_o && cmd_i.fin_vld;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
      if (adv[3]) vld_q[3] <= vld_q[2];
      if (out_rdy) out_vld_q <= vld_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      h1_q     <= h_cmd;
      held1_q  <= cmd_i.held;
      cnt1_q   <= cmd_i.count;
      empty1_q <= cmd_i.empty;
    end
    // An empty message mixes to zero, so zero it before the tail
    if (adv[1]) h2_q <= tail_mix(empty1_q ? '0 : h1_q, held1_q, cnt1_q);
    if (adv[2]) h3_q <= aval_a(h2_q);
    if (adv[3]) h4_q <= aval_b(h3_q);
    if (out_rdy) out_q <= aval_c(h4_q);
  end

  assign hash_valid_o      = out_vld_q;
  assign hash_value_o      = out_q;
  assign status_o.pipe_vld = vld_q;

endmodule

// ===== rtl/superfast_stream_hash.sv =====
// Stream hash: one message byte per cycle, one 32-bit hash per message.
// Throughput: one item accepted every cycle when the output is taken.
// After the end item is accepted, the hash passes through the command queue,
// finish stage, tail stage, two avalanche stages and the output register.
// Reset (rst_ni low, asynchronous): block goes idle, queue and pipeline empty.
// ----------------------------------------------------------------------------
// superfast_stream_hash
// Top level: front end, command queue and back end.
// ----------------------------------------------------------------------------
module superfast_stream_hash import ssh_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             byte_present_i,
  input  logic             message_start_i,
  input  logic             message_end_i,
  input  logic [HashW-1:0] message_length_i,
  output logic             hash_valid_o,
  input  logic             hash_ready_i,
  output logic [HashW-1:0] hash_value_o
);

  logic       push;
  cmd_t       cmd_in;
  logic       full;
  logic       cmd_valid;
  cmd_t       cmd_out;
  logic       pop;
  logic [1:0] fifo_cnt;
  bk_status_t bk_status;

  ssh_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .byte_present_i   (byte_present_i),
    .message_start_i  (message_start_i),
    .message_end_i    (message_end_i),
    .message_length_i (message_length_i),
    .cmd_push_o       (push),
    .cmd_o            (cmd_in),
    .cmd_full_i       (full)
  );

  ssh_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_out),
    .pop_i   (pop),
    .cnt_o   (fifo_cnt)
  );

  ssh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd_out),
    .cmd_pop_o    (pop),
    .hash_valid_o (hash_valid_o),
    .hash_ready_i (hash_ready_i),
    .hash_value_o (hash_value_o),
    .status_o     (bk_status)
  );

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt <= 2'd2)
    else $error("command queue count out of range");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> fifo_cnt == 2'd2)
    else $error("input stalled while queue has room");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(hash_valid_o) |-> $past(bk_status.pipe_vld[PipeStages-1]))
    else $error("hash shown without a finished message");

endmodule
